[rtl/spdc_pkg.sv]
package spdc_pkg;

	// Parser phase, one-hot
	typedef enum logic [6:0] {
		PH_RX_ID  = 7'b0000001,
		PH_SND_ID = 7'b0000010,
		PH_TARGET = 7'b0000100,
		PH_PTYPE  = 7'b0001000,
		PH_LENGTH = 7'b0010000,
		PH_PAYLD  = 7'b0100000,
		PH_CSUM   = 7'b1000000
	} phase_t;

	typedef enum logic [2:0] {
		EV_SKIP     = 3'd0,
		EV_HEADER   = 3'd1,
		EV_PAYLOAD  = 3'd2,
		EV_GOOD     = 3'd3,
		EV_CSUM_BAD = 3'd4,
		EV_REJECT   = 3'd5,
		EV_OVERFLOW = 3'd6
	} event_t;

	typedef enum logic [1:0] {
		REG_OWN_ID    = 2'd0,
		REG_UI_ID     = 2'd1,
		REG_DRIVER_ID = 2'd2,
		REG_BCAST_ID  = 2'd3
	} reg_idx_t;

	localparam logic [7:0] TARGET_ONE = 8'd1;
	localparam logic [8:0] COUNT_TOP  = 9'd511;

	typedef struct packed {
		logic [7:0] own_id;
		logic [7:0] ui_sender_id;
		logic [7:0] driver_sender_id;
		logic [7:0] broadcast_id;
	} cfg_t;

	typedef struct packed {
		event_t     ev;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [7:0] packet_type;
		logic [7:0] payload_length;
		logic [7:0] sender_id;
	} result_t;

endpackage

[rtl/serial_packet_deframer_checksum.sv]
// Packet deframer for a received byte stream with an 8-bit two's-complement checksum.
// Input stream (s_*): one received byte per transfer in s_tdata[7:0].
// Output stream (m_*): exactly one result per input byte, in order.
//   m_tuser carries the event code, m_tdata the payload byte, its index and
//   the held type, length and sender of the current packet.
// Config port: cfg_we with cfg_index/cfg_wdata writes one id register per
//   clock; write only while the block is idle.
// Output: each result is registered and appears on m_* in the cycle after its byte's transfer.
// Throughput: one byte per cycle while the output is not stalled; the parser
//   state updates as each byte is taken, so bytes may come back to back.
// Stall: the output register holds its result while m_tready is low; a new
//   byte is still taken in the cycle that the held result leaves
//   (s_tready = !m_tvalid || m_tready).
// Reset (arst_n low): parser hunts for the receiver id, counters and held
//   fields clear, id registers return to their defaults, output is empty.
module serial_packet_deframer_checksum
	import spdc_pkg::*;
#(
	parameter int MAX_PAYLOAD = 248,
	parameter int MAX_PACKET  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// payload_byte, payload_index, packet_type, payload_length, sender_id
	output logic [39:0] m_tdata,
	output logic [2:0]  m_tuser,   // event_res
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);

	cfg_t    cfg;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    take;

	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;

	spdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (reg_idx_t'(cfg_index)),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	spdc_core #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.MAX_PACKET  (MAX_PACKET)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (s_tdata),
		.cfg     (cfg),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.ev;
	assign m_tdata  = {res_q.sender_id, res_q.payload_length, res_q.packet_type,
	                   res_q.payload_index, res_q.payload_byte};

endmodule

[rtl/spdc_cfg_regs.sv]
module spdc_cfg_regs
	import spdc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  reg_idx_t   cfg_index,
	input  logic [7:0] cfg_wdata,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_id           <= 8'd172;
			cfg_q.ui_sender_id     <= 8'd184;
			cfg_q.driver_sender_id <= 8'd183;
			cfg_q.broadcast_id     <= 8'd254;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OWN_ID:    cfg_q.own_id           <= cfg_wdata;
				REG_UI_ID:     cfg_q.ui_sender_id     <= cfg_wdata;
				REG_DRIVER_ID: cfg_q.driver_sender_id <= cfg_wdata;
				REG_BCAST_ID:  cfg_q.broadcast_id     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/spdc_core.sv]
module spdc_core
	import spdc_pkg::*;
#(
	parameter int MAX_PAYLOAD = 248,
	parameter int MAX_PACKET  = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output result_t    res
);

	localparam logic [8:0] MaxPayload = 9'(MAX_PAYLOAD);
	localparam logic [8:0] MaxPacket  = 9'(MAX_PACKET);

	phase_t     phase_q, phase_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] pay_cnt_q, pay_cnt_d;
	logic [7:0] len_q, len_d;
	logic [8:0] pkt_cnt_q, pkt_cnt_d;
	logic [7:0] ptype_q, ptype_d;
	logic [7:0] sender_q, sender_d;

	logic [7:0] sum_add;
	logic [8:0] pkt_inc;
	logic [8:0] pay_next;

	assign sum_add  = sum_q + rx_byte;
	assign pkt_inc  = (pkt_cnt_q < COUNT_TOP) ? pkt_cnt_q + 9'd1 : pkt_cnt_q;
	assign pay_next = {1'b0, pay_cnt_q} + 9'd1;

	always_comb begin
		phase_d   = phase_q;
		sum_d     = sum_q;
		pay_cnt_d = pay_cnt_q;
		len_d     = len_q;
		pkt_cnt_d = pkt_cnt_q;
		ptype_d   = ptype_q;
		sender_d  = sender_q;
		res.ev            = EV_SKIP;
		res.payload_byte  = 8'd0;
		res.payload_index = 8'd0;

		if (pkt_cnt_q >= MaxPacket) begin
			phase_d   = PH_RX_ID;
			pkt_cnt_d = 9'd0;
			res.ev    = EV_OVERFLOW;
		end else begin
			unique case (phase_q)
				PH_RX_ID: begin
					if (rx_byte == cfg.own_id) begin
						sum_d     = rx_byte;
						pkt_cnt_d = 9'd1;
						phase_d   = PH_SND_ID;
						res.ev    = EV_HEADER;
					end else begin
						pkt_cnt_d = 9'd0;
					end
				end
				PH_SND_ID: begin
					if (rx_byte == cfg.ui_sender_id || rx_byte == cfg.driver_sender_id) begin
						sum_d     = sum_add;
						pkt_cnt_d = pkt_inc;
						sender_d  = rx_byte;
						phase_d   = PH_TARGET;
						res.ev    = EV_HEADER;
					end else begin
						phase_d   = PH_RX_ID;
						pkt_cnt_d = 9'd0;
						res.ev    = EV_REJECT;
					end
				end
				PH_TARGET: begin
					if (rx_byte == TARGET_ONE || rx_byte == cfg.broadcast_id) begin
						sum_d     = sum_add;
						pkt_cnt_d = pkt_inc;
						phase_d   = PH_PTYPE;
						res.ev    = EV_HEADER;
					end else begin
						phase_d   = PH_RX_ID;
						pkt_cnt_d = 9'd0;
						res.ev    = EV_REJECT;
					end
				end
				PH_PTYPE: begin
					sum_d     = sum_add;
					pkt_cnt_d = pkt_inc;
					ptype_d   = rx_byte;
					phase_d   = PH_LENGTH;
					res.ev    = EV_HEADER;
				end
				PH_LENGTH: begin
					sum_d     = sum_add;
					pkt_cnt_d = pkt_inc;
					len_d     = rx_byte;
					pay_cnt_d = 8'd0;
					// zero length goes straight to the checksum
					phase_d   = (rx_byte == 8'd0) ? PH_CSUM : PH_PAYLD;
					res.ev    = EV_HEADER;
				end
				PH_PAYLD: begin
					sum_d     = sum_add;
					pkt_cnt_d = pkt_inc;
					pay_cnt_d = pay_next[7:0];
					if (pay_next >= MaxPayload) begin
						phase_d = PH_RX_ID;
						res.ev  = EV_OVERFLOW;
					end else begin
						if (pay_next >= {1'b0, len_q})
							phase_d = PH_CSUM;
						res.ev            = EV_PAYLOAD;
						res.payload_byte  = rx_byte;
						res.payload_index = pay_cnt_q;
					end
				end
				PH_CSUM: begin
					sum_d     = sum_add;
					pkt_cnt_d = 9'd0;
					phase_d   = PH_RX_ID;
					res.ev    = (sum_add == 8'd0) ? EV_GOOD : EV_CSUM_BAD;
				end
				default: begin
					phase_d = PH_RX_ID;
				end
			endcase
		end

		res.packet_type    = ptype_d;
		res.payload_length = len_d;
		res.sender_id      = sender_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_RX_ID;
			sum_q     <= 8'd0;
			pay_cnt_q <= 8'd0;
			len_q     <= 8'd0;
			pkt_cnt_q <= 9'd0;
			ptype_q   <= 8'd0;
			sender_q  <= 8'd0;
		end else if (take) begin
			phase_q   <= phase_d;
			sum_q     <= sum_d;
			pay_cnt_q <= pay_cnt_d;
			len_q     <= len_d;
			pkt_cnt_q <= pkt_cnt_d;
			ptype_q   <= ptype_d;
			sender_q  <= sender_d;
		end
	end

endmodule

[bench/spdc_checker.sv]
// Watches both streams and the config port of the deframer, predicts one
// result per accepted byte and compares the results in order.
module spdc_checker
	import spdc_pkg::*;
#(
	parameter int MAX_PAYLOAD = 248,
	parameter int MAX_PACKET  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	// payload_byte, payload_index, packet_type, payload_length, sender_id
	input  logic [39:0] m_tdata,
	input  logic [2:0]  m_tuser,   // event_res
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata,
	output int          mismatch_count,
	output int          results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	// predictor state
	cfg_t       ids;
	phase_t     ph;
	logic [7:0] csum;
	logic [7:0] pay_cnt;
	logic [7:0] len_hold;
	logic [7:0] type_hold;
	logic [7:0] sender_hold;
	logic [8:0] pkt_cnt;

	result_t byte_results_q[$];

	initial mismatch_count = 0;

	task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("%0t: %s: got %h, expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	function automatic void take_byte(input logic [7:0] b);
		csum = csum + b;
		if (pkt_cnt < COUNT_TOP)
			pkt_cnt = pkt_cnt + 9'd1;
	endfunction

	function automatic result_t deframe_byte(input logic [7:0] b);
		result_t r;
		int      next;
		r = '0;
		r.ev = EV_SKIP;
		if (pkt_cnt >= MAX_PACKET) begin
			ph = PH_RX_ID;
			pkt_cnt = '0;
			r.ev = EV_OVERFLOW;
		end else begin
			case (ph)
				PH_RX_ID: begin
					pkt_cnt = '0;
					if (b == ids.own_id) begin
						csum = '0;
						take_byte(b);
						ph = PH_SND_ID;
						r.ev = EV_HEADER;
					end
				end
				PH_SND_ID: begin
					if (b == ids.ui_sender_id || b == ids.driver_sender_id) begin
						take_byte(b);
						sender_hold = b;
						ph = PH_TARGET;
						r.ev = EV_HEADER;
					end else begin
						ph = PH_RX_ID;
						pkt_cnt = '0;
						r.ev = EV_REJECT;
					end
				end
				PH_TARGET: begin
					if (b == TARGET_ONE || b == ids.broadcast_id) begin
						take_byte(b);
						ph = PH_PTYPE;
						r.ev = EV_HEADER;
					end else begin
						ph = PH_RX_ID;
						pkt_cnt = '0;
						r.ev = EV_REJECT;
					end
				end
				PH_PTYPE: begin
					take_byte(b);
					type_hold = b;
					ph = PH_LENGTH;
					r.ev = EV_HEADER;
				end
				PH_LENGTH: begin
					take_byte(b);
					len_hold = b;
					pay_cnt = '0;
					ph = (b == 8'd0) ? PH_CSUM : PH_PAYLD;
					r.ev = EV_HEADER;
				end
				PH_PAYLD: begin
					take_byte(b);
					next = int'(pay_cnt) + 1;
					r.payload_index = pay_cnt;
					pay_cnt = next[7:0];
					if (next >= MAX_PAYLOAD) begin
						ph = PH_RX_ID;
						r.ev = EV_OVERFLOW;
						r.payload_index = '0;
					end else begin
						if (next >= int'(len_hold))
							ph = PH_CSUM;
						r.ev = EV_PAYLOAD;
						r.payload_byte = b;
					end
				end
				PH_CSUM: begin
					take_byte(b);
					r.ev = (csum == 8'd0) ? EV_GOOD : EV_CSUM_BAD;
					pkt_cnt = '0;
					ph = PH_RX_ID;
				end
				default: begin
					ph = PH_RX_ID;
					r.ev = EV_SKIP;
				end
			endcase
		end
		r.packet_type = type_hold;
		r.payload_length = len_hold;
		r.sender_id = sender_hold;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			ids.own_id = 8'd172;
			ids.ui_sender_id = 8'd184;
			ids.driver_sender_id = 8'd183;
			ids.broadcast_id = 8'd254;
			ph = PH_RX_ID;
			csum = '0;
			pay_cnt = '0;
			len_hold = '0;
			type_hold = '0;
			sender_hold = '0;
			pkt_cnt = '0;
			byte_results_q.delete();
			results_owed <= 0;
		end else begin
			// results are registered before they leave, so compare before predicting
			if (m_tvalid && m_tready) begin
				if (byte_results_q.size() == 0) begin
					report_mismatch("result with nothing expected, event", 8'(m_tuser), 8'd0);
				end else begin
					want = byte_results_q.pop_front();
					if (m_tuser !== want.ev)
						report_mismatch("event", 8'(m_tuser), 8'(want.ev));
					if (m_tdata[7:0] !== want.payload_byte)
						report_mismatch("payload_byte", m_tdata[7:0], want.payload_byte);
					if (m_tdata[15:8] !== want.payload_index)
						report_mismatch("payload_index", m_tdata[15:8], want.payload_index);
					if (m_tdata[23:16] !== want.packet_type)
						report_mismatch("packet_type", m_tdata[23:16], want.packet_type);
					if (m_tdata[31:24] !== want.payload_length)
						report_mismatch("payload_length", m_tdata[31:24], want.payload_length);
					if (m_tdata[39:32] !== want.sender_id)
						report_mismatch("sender_id", m_tdata[39:32], want.sender_id);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_OWN_ID:    ids.own_id = cfg_wdata;
					REG_UI_ID:     ids.ui_sender_id = cfg_wdata;
					REG_DRIVER_ID: ids.driver_sender_id = cfg_wdata;
					REG_BCAST_ID:  ids.broadcast_id = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				byte_results_q.push_back(deframe_byte(s_tdata));
			results_owed <= byte_results_q.size();
		end
	end

endmodule

[bench/serial_packet_deframer_checksum_tb.sv]
// Stimulus and verdict for the packet deframer; checking lives in spdc_checker.
module serial_packet_deframer_checksum_tb
	import spdc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PAYLOAD = 248;
	localparam int MAX_PACKET  = 256;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;      // rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// payload_byte, payload_index, packet_type, payload_length, sender_id
	logic [39:0] m_tdata;
	logic [2:0]  m_tuser;           // event_res
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_wdata = '0;

	int mismatch_total;
	int results_owed;

	// idle odds per cycle, in percent
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	// long receiver hold-off: stimulus bumps the request, receiver serves it
	int hold_asked = 0;
	int hold_served = 0;
	int hold_left = 0;

	int bytes_sent = 0;

	// ids the block currently holds, used to build well-formed frames
	logic [7:0] own_now = 8'd172;
	logic [7:0] ui_now = 8'd184;
	logic [7:0] drv_now = 8'd183;
	logic [7:0] bcast_now = 8'd254;

	serial_packet_deframer_checksum #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.MAX_PACKET (MAX_PACKET)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	spdc_checker #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.MAX_PACKET (MAX_PACKET)
	) u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.mismatch_count(mismatch_total),
		.results_owed  (results_owed)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: random ready, or a long hold-off when one is requested so the
	// output register fills and s_tready drops while bytes keep coming.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_served) begin
			m_tready <= 1'b0;
			hold_left <= 250;
			hold_served <= hold_asked;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Offer one byte, idling at random first; returns once the transfer happened.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Stop offering and wait until every result has been taken, plus the
	// output latency and a little margin. Sender pause and config fence.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One write per clock; cfg_we stays high over the whole burst.
	task automatic write_ids(input logic [7:0] own, ui, drv, bcast);
		cfg_we <= 1'b1;
		cfg_index <= REG_OWN_ID;
		cfg_wdata <= own;
		@(posedge clk);
		cfg_index <= REG_UI_ID;
		cfg_wdata <= ui;
		@(posedge clk);
		cfg_index <= REG_DRIVER_ID;
		cfg_wdata <= drv;
		@(posedge clk);
		cfg_index <= REG_BCAST_ID;
		cfg_wdata <= bcast;
		@(posedge clk);
		cfg_we <= 1'b0;
		own_now = own;
		ui_now = ui;
		drv_now = drv;
		bcast_now = bcast;
	endtask

	// Full frame from the receiver id on. Lengths at or past MAX_PAYLOAD end in
	// the payload overflow, so no checksum byte is sent for them.
	task automatic send_frame(input logic [7:0] snd, tgt, ptype, len, input bit corrupt);
		logic [7:0] hdr [5];
		logic [7:0] sum;
		logic [7:0] pb;
		int         n;
		hdr = '{own_now, snd, tgt, ptype, len};
		sum = '0;
		foreach (hdr[i]) begin
			sum = sum + hdr[i];
			send_byte(hdr[i]);
		end
		n = (int'(len) >= MAX_PAYLOAD) ? MAX_PAYLOAD : int'(len);
		for (int i = 0; i < n; i++) begin
			pb = 8'($urandom);
			sum = sum + pb;
			send_byte(pb);
		end
		if (int'(len) < MAX_PAYLOAD) begin
			sum = -sum;
			if (corrupt)
				sum = sum + 8'($urandom_range(1, 255));
			send_byte(sum);
		end
	endtask

	// Mostly well-formed frames with random content, some line noise and
	// frames broken in the header.
	task automatic random_item();
		int         pick;
		int         lpick;
		logic [7:0] len;
		pick = $urandom_range(99);
		if (pick < 8) begin
			send_byte(8'($urandom));
		end else if (pick < 14) begin
			send_byte(own_now);
			send_byte(8'($urandom));
			if (pick < 11)
				send_byte(8'($urandom));
		end else begin
			lpick = $urandom_range(99);
			if (lpick < 75)
				len = 8'($urandom_range(0, 8));
			else if (lpick < 97)
				len = 8'($urandom_range(9, 40));
			else if (lpick < 99)
				len = 8'($urandom_range(241, 247));
			else
				len = 8'($urandom_range(248, 255));
			send_frame($urandom_range(1) ? ui_now : drv_now,
				$urandom_range(1) ? TARGET_ONE : bcast_now,
				8'($urandom), len, $urandom_range(99) < 15);
		end
	endtask

	initial begin
		int start;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < 6; p++) begin
			// sender mostly busy / receiver mostly stalled, then swapped, then free-running
			if (p < 2) begin
				tx_idle_pct = 30;
				rx_idle_pct = 84;
			end else if (p < 4) begin
				tx_idle_pct = 84;
				rx_idle_pct = 30;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			if (p > 0)
				drain();
			case (p)
				1: write_ids(8'h00, 8'h00, 8'hFF, 8'h00);
				2: write_ids(8'hFF, 8'hFF, 8'h00, 8'hFF);
				3, 4: write_ids(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				5: write_ids(8'd172, 8'd184, 8'd183, 8'd254);
				default: ;
			endcase

			if (p == 0) begin
				// directed: noise, zero length, both senders and targets, type
				// extremes, wrong sender, wrong target, bad checksum
				send_byte(8'h00);
				send_frame(ui_now, TARGET_ONE, 8'h00, 8'h00, 1'b0);
				send_frame(drv_now, bcast_now, 8'hFF, 8'h02, 1'b0);
				send_byte(own_now);
				send_byte(~ui_now & ~drv_now);
				send_byte(own_now);
				send_byte(ui_now);
				send_byte(8'h02);
				send_frame(ui_now, TARGET_ONE, 8'h5A, 8'h01, 1'b1);
			end
			// payload longer than MAX_PAYLOAD ends in overflow
			if (p == 1 || p == 4)
				send_frame(ui_now, TARGET_ONE, 8'($urandom), 8'hFF, 1'b0);
			// receiver stops for a long stretch while the sender keeps going
			if (p == 5)
				hold_asked = hold_asked + 1;

			start = bytes_sent;
			while (bytes_sent - start < 200) begin
				random_item();
				// sender waits mid-phase until all results are out
				if (p == 3 && bytes_sent - start >= 100 && bytes_sent - start < 115)
					drain();
			end
		end

		drain();
		if (mismatch_total == 0)
			$display("serial_packet_deframer_checksum_tb OK");
		else
			$display("serial_packet_deframer_checksum_tb NOT OK");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("serial_packet_deframer_checksum_tb NOT OK");
		$finish;
	end

endmodule

[sim.f]
rtl/spdc_pkg.sv
rtl/spdc_cfg_regs.sv
rtl/spdc_core.sv
rtl/serial_packet_deframer_checksum.sv
bench/spdc_checker.sv
bench/serial_packet_deframer_checksum_tb.sv
